@@ hw/rtl/bdab_pkg.sv @@
// bdab_pkg: shared constants, types and weight functions for the binary to
// decimal ascii converter with leading-zero blanking
// no dependencies; used by bdab_cell and binary_to_decimal_ascii_blanking
package bdab_pkg;

    localparam int DIGITS  = 7;
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;

    function automatic logic [35:0] pow10(input int n);
        logic [35:0] p;
        p = 36'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 36'd10;
        end
        return p;
    endfunction

    localparam logic [35:0] LIMIT = pow10(DIGITS);
    localparam int REM_W = $clog2(LIMIT);
    localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    typedef logic [REM_W-1:0]  t_rem;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [3:0]        t_digit;
    typedef logic [CHAR_W-1:0] t_char;

    typedef struct packed {
        logic ovf;
        logic blank;
        logic lead;
        t_rem rem;
    } t_cell;

    // d times the decimal weight of position pos (pos 0 is most significant)
    function automatic t_rem weight_mult(input t_pos pos, input t_digit d);
        logic [35:0] w;
        logic [39:0] m;
        w = 36'd1;
        for (int i = 0; i < DIGITS - 1; i++) begin
            if (i < DIGITS - 1 - int'(pos)) begin
                w = w * 36'd10;
            end
        end
        m = {4'b0, w} * {36'b0, d};
        return m[REM_W-1:0];
    endfunction

endpackage

@@ hw/rtl/bdab_cell.sv @@
// bdab_cell: one decimal position of the converter chain
// extracts its digit from the remainder, forms the character, hands the rest on
// depends on bdab_pkg
module bdab_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdab_pkg::t_pos    i_pos,
    input  logic              i_en,
    input  logic              i_vld,
    input  bdab_pkg::t_cell   i_d,
    output logic              o_vld,
    output bdab_pkg::t_cell   o_next,
    output bdab_pkg::t_char   o_char,
    output logic              o_last,
    output logic              o_ovf
);

    logic             r_vld;
    bdab_pkg::t_cell  r_d;
    bdab_pkg::t_digit w_dig;
    bdab_pkg::t_rem   w_sub;
    bdab_pkg::t_rem   w_mult;
    logic             w_last;
    logic             w_blank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= i_d;
        end
    end

    always_comb begin
        w_dig  = 4'd0;
        w_sub  = '0;
        w_mult = '0;
        for (int d = 1; d < 10; d++) begin
            w_mult = bdab_pkg::weight_mult(i_pos, 4'(d));
            if (r_d.rem >= w_mult) begin
                w_dig = 4'(d);
                w_sub = w_mult;
            end
        end
        if (r_d.ovf) begin
            w_dig = 4'd9;
        end
    end

    assign w_last  = (i_pos == bdab_pkg::POS_W'(bdab_pkg::DIGITS - 1));
    assign w_blank = r_d.blank && r_d.lead && !w_last && (w_dig == 4'd0);

    assign o_vld        = r_vld;
    assign o_char       = w_blank ? bdab_pkg::CHAR_SPACE
                                  : bdab_pkg::CHAR_ZERO + {2'b00, w_dig};
    assign o_last       = w_last;
    assign o_ovf        = r_d.ovf;
    assign o_next.ovf   = r_d.ovf;
    assign o_next.blank = r_d.blank;
    assign o_next.lead  = w_blank;
    assign o_next.rem   = r_d.rem - w_sub;

endmodule

@@ hw/rtl/binary_to_decimal_ascii_blanking.sv @@
// binary_to_decimal_ascii_blanking: binary value to ascii decimal characters
// top level; a row of bdab_cell positions feeding one output register
// depends on bdab_pkg and bdab_cell
//
// usage:
//   input channel i_valid / o_stall / i_value carries one 32-bit unsigned value
//   per item. output channel o_valid / i_stall gives one character per item:
//   o_digit_char, o_last_char on the least significant one, o_overflow on all
//   characters of a value above the largest the digits can show (shown as 9s).
//   config channel i_cfg_valid / o_cfg_ready / i_cfg_data sets blank_zeros;
//   write it only while idle. o_cfg_ready is always high.
// timing:
//   a value enters the first cell and moves one cell per cycle unless the
//   output stalls; each cell emits its character into the output register.
//   the row takes no new value while the previous one is short of its last cell;
//   the next value is taken in the cycle the last character leaves the row.
// reset: the row and output register empty, blank_zeros set to 1.
// stall: when i_stall holds a waiting character the whole row freezes; a new
//   value is still taken into an empty row.
module binary_to_decimal_ascii_blanking (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_digit_char,
    output logic        o_last_char,
    output logic        o_overflow,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int NDIG = bdab_pkg::DIGITS;
    localparam logic [NDIG-1:0] LAST_MASK = NDIG'(1) << (NDIG - 1);

    logic                 r_blank;
    logic                 r_out_vld;
    bdab_pkg::t_char      r_char;
    logic                 r_last;
    logic                 r_ovf;

    logic                 w_adv;
    logic                 w_ready;
    logic                 w_acc;
    logic [35:0]          w_value_x;
    bdab_pkg::t_cell      w_load;
    logic [NDIG-1:0]      w_busy;
    bdab_pkg::t_cell      w_next [NDIG];
    bdab_pkg::t_char      w_char [NDIG];
    logic [NDIG-1:0]      w_last;
    logic [NDIG-1:0]      w_ovf;
    bdab_pkg::t_char      w_sel_char;
    logic                 w_sel_last;
    logic                 w_sel_ovf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= 1'b1;
        end else if (i_cfg_valid) begin
            r_blank <= i_cfg_data;
        end
    end

    assign w_adv   = !r_out_vld || !i_stall;
    assign w_ready = (w_busy == '0) || (w_adv && (w_busy == LAST_MASK));
    assign w_acc   = i_valid && w_ready;
    assign o_stall = !w_ready;

    assign w_value_x    = {4'b0000, i_value};
    assign w_load.ovf   = (w_value_x >= bdab_pkg::LIMIT);
    assign w_load.blank = r_blank;
    assign w_load.lead  = 1'b1;
    assign w_load.rem   = w_value_x[bdab_pkg::REM_W-1:0];

    for (genvar k = 0; k < NDIG; k++) begin : g_cell
        if (k == 0) begin : g_first
            bdab_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_pos   (bdab_pkg::POS_W'(k)),
                .i_en    (w_adv || w_acc),
                .i_vld   (w_acc),
                .i_d     (w_load),
                .o_vld   (w_busy[k]),
                .o_next  (w_next[k]),
                .o_char  (w_char[k]),
                .o_last  (w_last[k]),
                .o_ovf   (w_ovf[k])
            );
        end else begin : g_rest
            bdab_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_pos   (bdab_pkg::POS_W'(k)),
                .i_en    (w_adv),
                .i_vld   (w_busy[k-1]),
                .i_d     (w_next[k-1]),
                .o_vld   (w_busy[k]),
                .o_next  (w_next[k]),
                .o_char  (w_char[k]),
                .o_last  (w_last[k]),
                .o_ovf   (w_ovf[k])
            );
        end
    end

    // at most one cell holds an item
    always_comb begin
        w_sel_char = '0;
        w_sel_last = 1'b0;
        w_sel_ovf  = 1'b0;
        for (int k = 0; k < NDIG; k++) begin
            if (w_busy[k]) begin
                w_sel_char = w_char[k];
                w_sel_last = w_last[k];
                w_sel_ovf  = w_ovf[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= |w_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_char <= w_sel_char;
            r_last <= w_sel_last;
            r_ovf  <= w_sel_ovf;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_digit_char = r_char;
    assign o_last_char  = r_last;
    assign o_overflow   = r_ovf;

endmodule

@@ tb/binary_to_decimal_ascii_blanking_checker.sv @@
`timescale 1ns / 1ps
// checker for binary_to_decimal_ascii_blanking: watches the value, character and
// config channels, predicts the decimal characters and compares them in order
// depends on bdab_pkg for the digit count and character types
module binary_to_decimal_ascii_blanking_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [31:0] i_value,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [5:0]  o_digit_char,
    input  logic        o_last_char,
    input  logic        o_overflow,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output int          o_pending,
    output int          o_fails,
    output int          o_checked
);

    typedef struct packed {
        bdab_pkg::t_char ch;
        logic            last;
        logic            ovf;
    } t_char_item;

    t_char_item expected_chars[$];
    logic       blank_zeros = 1'b1;
    int         fail_count = 0;
    int         checked_count = 0;
    int         pending_count = 0;

    assign o_fails   = fail_count;
    assign o_checked = checked_count;
    assign o_pending = pending_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic void predict_chars(input logic [31:0] value, input logic blank);
        logic [63:0]      rest;
        logic [63:0]      limit;
        bdab_pkg::t_digit digs[bdab_pkg::DIGITS];
        logic             ovf;
        logic             leading;
        logic             last;
        t_char_item       item;
        limit = 64'd1;
        for (int k = 0; k < bdab_pkg::DIGITS; k++) begin
            limit = limit * 64'd10;
        end
        rest = {32'd0, value};
        ovf = rest >= limit;
        for (int k = bdab_pkg::DIGITS - 1; k >= 0; k--) begin
            if (ovf) begin
                digs[k] = 4'd9;
            end else begin
                digs[k] = bdab_pkg::t_digit'(rest % 64'd10);
                rest = rest / 64'd10;
            end
        end
        leading = 1'b1;
        for (int k = 0; k < bdab_pkg::DIGITS; k++) begin
            last = (k == bdab_pkg::DIGITS - 1);
            item.ch = bdab_pkg::CHAR_ZERO + bdab_pkg::t_char'(digs[k]);
            if (blank && leading && !last && digs[k] == 4'd0) begin
                item.ch = bdab_pkg::CHAR_SPACE;
            end else begin
                leading = 1'b0;
            end
            item.last = last;
            item.ovf  = ovf;
            expected_chars.push_back(item);
        end
    endfunction

    task automatic check_char();
        t_char_item want;
        if (expected_chars.size() == 0) begin
            report_mismatch("unexpected character", 32'(o_digit_char), 32'd0);
        end else begin
            want = expected_chars.pop_front();
            checked_count++;
            if (o_digit_char !== want.ch) begin
                report_mismatch("digit_char", 32'(o_digit_char), 32'(want.ch));
            end
            if (o_last_char !== want.last) begin
                report_mismatch("last_char", 32'(o_last_char), 32'(want.last));
            end
            if (o_overflow !== want.ovf) begin
                report_mismatch("overflow", 32'(o_overflow), 32'(want.ovf));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blank_zeros = 1'b1;
            expected_chars.delete();
        end else begin
            if (o_valid && !i_stall) begin
                check_char();
            end
            if (i_cfg_valid && o_cfg_ready) begin
                blank_zeros = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                predict_chars(i_value, blank_zeros);
            end
        end
        pending_count <= expected_chars.size();
    end

endmodule

@@ tb/binary_to_decimal_ascii_blanking_tb.sv @@
`timescale 1ns / 1ps
// testbench top for binary_to_decimal_ascii_blanking: clock, reset, value and
// config stimulus with random gaps and stalls, verdict from the checker
// depends on bdab_pkg, the block and binary_to_decimal_ascii_blanking_checker
module binary_to_decimal_ascii_blanking_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_digit_char;
    logic        o_last_char;
    logic        o_overflow;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    int   pending;
    int   fails;
    int   checked;
    int   values_sent = 0;
    int   blank_writes = 0;
    logic gaps_on = 1'b1;
    logic stalls_on = 1'b1;
    int   stall_left = 0;

    binary_to_decimal_ascii_blanking u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last_char  (o_last_char),
        .o_overflow   (o_overflow),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    binary_to_decimal_ascii_blanking_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last_char  (o_last_char),
        .o_overflow   (o_overflow),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fails      (fails),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // receiver stalls in bursts of random length
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    i_stall <= 1'b0;
                end
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                stall_left = $urandom_range(1, 4);
            end
        end
    end

    initial begin
        #5ms;
        $display("timeout with %0d characters still expected", pending);
        $display("binary_to_decimal_ascii_blanking_tb failed");
        $finish;
    end

    task automatic send_value(input logic [31:0] value);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        values_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_blank(input logic blank);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= blank;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        blank_writes++;
    endtask

    function automatic logic [31:0] random_value();
        int          pick;
        int          n;
        logic [63:0] span;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        span = 64'd1;
        for (int k = 0; k < bdab_pkg::DIGITS; k++) begin
            span = span * 64'd10;
        end
        if (pick < 40) begin
            n = $urandom_range(1, bdab_pkg::DIGITS);
            span = 64'd1;
            repeat (n) span = span * 64'd10;
            v = (span > 64'hFFFF_FFFF) ? $urandom : $urandom_range(0, 32'(span - 1));
        end else if (pick < 55) begin
            v = $urandom_range(0, 20);
        end else if (pick < 70) begin
            // random digits with many zeros among them
            v = 32'd0;
            repeat (bdab_pkg::DIGITS) begin
                v = v * 10 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9));
            end
        end else if (pick < 80) begin
            v = 32'(span - 64'd10) + $urandom_range(0, 20);
        end else if (pick < 85) begin
            v = 32'hFFFF_FFFF - $urandom_range(0, 15);
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_value     <= 32'd0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blanking on after reset
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd1000000);
        send_value(32'd1020304);
        send_value(32'd9999999);
        send_value(32'd10000000);
        send_value(32'hFFFF_FFFF);
        send_value(32'd40);

        write_blank(1'b0);
        send_value(32'd0);
        send_value(32'd7);
        send_value(32'd100);
        send_value(32'd9999999);
        send_value(32'd10000000);
        send_value(32'hFFFF_FFFF);

        write_blank(1'b1);
        send_value(32'd5000000);
        send_value(32'd100001);
        send_value(32'h8000_0000);
        send_value(32'd0);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0) begin
                write_blank(1'b0);
            end else if (phase == 1) begin
                write_blank(1'b1);
            end else begin
                write_blank(1'($urandom_range(0, 1)));
            end
            if (phase == 5) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            for (int i = 0; i < 82; i++) begin
                if (phase == 2 && i == 40) begin
                    wait_drained();
                end
                send_value(random_value());
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("sent %0d values across %0d blanking writes, %0d characters checked",
                 values_sent, blank_writes, checked);
        if (fails == 0) begin
            $display("binary_to_decimal_ascii_blanking_tb passed");
        end else begin
            $display("%0d mismatches", fails);
            $display("binary_to_decimal_ascii_blanking_tb failed");
        end
        $finish;
    end

endmodule
